// File: sv/lbsm_pkg.sv
package lbsm_pkg;

  localparam int DEF_SLOTS    = 16;
  localparam int DEF_KEY_BITS = 32;

  // result slot field is fixed at four bits
  localparam int SLOT_W = 4;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INVAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

endpackage

// File: sv/lru_buffer_slot_manager.sv
// Fully associative tag store with least recently used replacement for SLOTS
// block slots. Each input beat carries a mode in s_tuser (read, write or
// invalidate all) and a hashed block key in s_tdata; each accepted beat gives
// exactly one result beat on the m side. A hit returns the resident slot; a
// miss takes the lowest free slot or else evicts the least recently used one
// and reports its key, and a read miss also raises need_fill. Keys and
// recency ranks live in two single-port-read synchronous memories that are
// walked one entry per cycle: a lookup pass finds the hit, the first free slot
// and the oldest slot, then an update pass rewrites the ranks. An invalidate
// or an unused mode skips both passes. One item is in work at a time, and
// the next can be accepted while the previous result still waits on m_tready.
module lru_buffer_slot_manager
  import lbsm_pkg::*;
#(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int IN_W    = ((KEY_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((SLOT_W + 3 + KEY_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // block_key
  input  logic [MODE_W-1:0] s_tuser,   // mode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // slot, hit, need_fill, evicted, evicted_key
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DEC  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state;

  // storage
  logic [KEY_BITS-1:0] tag_mem  [SLOTS];
  logic [IDX_W-1:0]    rank_mem [SLOTS];
  logic [KEY_BITS-1:0] tag_rd;
  logic [IDX_W-1:0]    rank_rd;
  logic [SLOTS-1:0]    valid;
  logic [CNT_W-1:0]    count;

  // item in work
  logic [KEY_BITS-1:0] key;
  logic                is_read;

  // walk pipeline: issue address, then check the returned entry
  logic [CNT_W-1:0] iss;
  logic             chk_v;
  logic [IDX_W-1:0] chk_idx;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  // lookup findings
  logic                hit_f;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    hit_rank;
  logic                free_f;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    vic_idx;
  logic [KEY_BITS-1:0] vic_key;

  // decision
  logic [IDX_W-1:0]    s_idx;
  logic                dec;
  logic [IDX_W-1:0]    ref_rank;
  logic [IDX_W-1:0]    new_rank;
  logic                r_hit;
  logic                r_fill;
  logic                r_ev;
  logic [KEY_BITS-1:0] r_evkey;

  // output register
  logic [SLOT_W-1:0]   o_slot;
  logic                o_hit;
  logic                o_fill;
  logic                o_ev;
  logic [KEY_BITS-1:0] o_evkey;

  logic             tag_we;
  logic [IDX_W-1:0] pick;
  logic             rank_we;
  logic [IDX_W-1:0] rank_wa;
  logic [IDX_W-1:0] rank_wd;
  logic             accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = OUT_W'({o_evkey, o_ev, o_fill, o_hit, o_slot});

  assign rd_en   = ((state == ST_SCAN) || (state == ST_UPD)) && (iss != CNT_END);
  assign rd_addr = iss[IDX_W-1:0];

  // miss target: lowest free slot, else the oldest one
  assign pick   = free_f ? free_idx : vic_idx;
  assign tag_we = (state == ST_DEC) && !hit_f;

  always_comb begin
    rank_we = 1'b0;
    rank_wa = chk_idx;
    rank_wd = rank_rd;
    if (state == ST_UPD && chk_v) begin
      if (chk_idx == s_idx) begin
        rank_we = 1'b1;
        rank_wd = new_rank;
      end else if (valid[chk_idx] && dec && (rank_rd > ref_rank)) begin
        // slots younger than the touched one move down one place
        rank_we = 1'b1;
        rank_wd = rank_rd - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_rd  <= tag_mem[rd_addr];
      rank_rd <= rank_mem[rd_addr];
    end
    if (tag_we) begin
      tag_mem[pick] <= key;
    end
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      valid    <= '0;
      count    <= '0;
      iss      <= '0;
      chk_v    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end

      if (rd_en) begin
        iss     <= iss + 1'b1;
        chk_v   <= 1'b1;
        chk_idx <= rd_addr;
      end else begin
        chk_v <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            key      <= s_tdata[KEY_BITS-1:0];
            is_read  <= (s_tuser == MODE_READ);
            hit_f    <= 1'b0;
            free_f   <= 1'b0;
            vic_idx  <= '0;
            vic_key  <= '0;
            s_idx    <= '0;
            r_hit    <= 1'b0;
            r_fill   <= 1'b0;
            r_ev     <= 1'b0;
            r_evkey  <= '0;
            iss      <= '0;
            if (s_tuser == MODE_READ || s_tuser == MODE_WRITE) begin
              state <= ST_SCAN;
            end else begin
              if (s_tuser == MODE_INVAL) begin
                valid <= '0;
                count <= '0;
              end
              state <= ST_FIN;
            end
          end
        end

        ST_SCAN: begin
          if (chk_v) begin
            if (valid[chk_idx] && (tag_rd == key) && !hit_f) begin
              hit_f    <= 1'b1;
              hit_idx  <= chk_idx;
              hit_rank <= rank_rd;
            end
            if (!valid[chk_idx] && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= chk_idx;
            end
            if (valid[chk_idx] && (rank_rd == '0)) begin
              vic_idx <= chk_idx;
              vic_key <= tag_rd;
            end
            if (chk_idx == LAST) begin
              iss   <= '0;
              state <= ST_DEC;
            end
          end
        end

        ST_DEC: begin
          if (hit_f) begin
            s_idx    <= hit_idx;
            r_hit    <= 1'b1;
            dec      <= 1'b1;
            ref_rank <= hit_rank;
            new_rank <= IDX_W'(count - 1'b1);
          end else if (free_f) begin
            s_idx           <= free_idx;
            r_fill          <= is_read;
            dec             <= 1'b0;
            ref_rank        <= '0;
            new_rank        <= count[IDX_W-1:0];
            valid[free_idx] <= 1'b1;
            count           <= count + 1'b1;
          end else begin
            s_idx    <= vic_idx;
            r_fill   <= is_read;
            r_ev     <= 1'b1;
            r_evkey  <= vic_key;
            dec      <= 1'b1;
            ref_rank <= '0;
            new_rank <= IDX_W'(count - 1'b1);
          end
          state <= ST_UPD;
        end

        ST_UPD: begin
          if (chk_v && chk_idx == LAST) begin
            iss   <= '0;
            state <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            o_slot   <= SLOT_W'(s_idx);
            o_hit    <= r_hit;
            o_fill   <= r_fill;
            o_ev     <= r_ev;
            o_evkey  <= r_evkey;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/lbsm_checker.sv
module lbsm_checker
  import lbsm_pkg::*;
#(
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int IN_W    = ((KEY_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((SLOT_W + 3 + KEY_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [IN_W-1:0]   s_tdata,
  input logic [MODE_W-1:0] s_tuser,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata
);

  localparam int HIT_B  = SLOT_W;
  localparam int FILL_B = SLOT_W + 1;
  localparam int EV_B   = SLOT_W + 2;
  localparam int KEY_LO = SLOT_W + 3;

  logic in_beat;
  assign in_beat = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

  // coming out of reset nothing is pending and input is open
  assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("lbsm: bad state after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("lbsm: stalled result beat changed");

  // one item in work at a time
  assert property (@(posedge clk) disable iff (rst) in_beat |=> !s_tready)
    else $error("lbsm: input reopened right after a beat");

  // a hit never fills or evicts, and the evicted key is zero unless evicted
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[HIT_B] && (m_tdata[FILL_B] || m_tdata[EV_B]))
                 && (m_tdata[EV_B] || (m_tdata[KEY_LO +: KEY_BITS] == '0)))
    else $error("lbsm: inconsistent result flags");

endmodule

bind lru_buffer_slot_manager lbsm_checker #(.KEY_BITS(KEY_BITS)) u_lbsm_checker (.*);
